[rtl/core/tcw_pkg.sv]
package tcw_pkg;

  // Field widths of the words on the ports
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;

  // Character codes and reset attribute
  localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'd10;
  localparam logic [CHAR_W-1:0] BACKSPACE_CODE = 8'd8;
  localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h07;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Action codes of an input word
  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] cursor_index;
    logic [COL_W-1:0]   cursor_column;
    logic [ROW_W-1:0]   cursor_row;
    logic [CELL_W-1:0]  cell_value;
  } out_word_t;

  // Decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUTC,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;
  } dec_word_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SPLIT,
    BK_PROW,
    BK_ADDR,
    BK_FILL,
    BK_WRITE,
    BK_RDREQ,
    BK_RDDATA,
    BK_REPORT
  } back_state_t;

endpackage

[rtl/core/tcw_ram.sv]
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read on one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/tcw_front.sv]
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  tcw_pkg::in_word_t cmd,
  output logic              dec_valid,
  input  logic              dec_ready,
  output tcw_pkg::dec_word_t dec
);

  localparam int CELLS = COLUMNS * ROWS;

  tcw_pkg::dec_word_t dec_next;

  assign cmd_ready = !dec_valid || dec_ready;

  // Classify the incoming word
  always_comb begin
    dec_next.char_code  = cmd.char_code;
    dec_next.cell_index = cmd.cell_index;
    unique case (cmd.action)
      tcw_pkg::ACT_PUT: begin
        if (cmd.char_code == tcw_pkg::NEWLINE_CODE) begin
          dec_next.op = tcw_pkg::OP_NEWLINE;
        end else if (cmd.char_code == tcw_pkg::BACKSPACE_CODE) begin
          dec_next.op = tcw_pkg::OP_BACKSPACE;
        end else begin
          dec_next.op = tcw_pkg::OP_PUTC;
        end
      end
      tcw_pkg::ACT_READ: begin
        // out of range reads report zero and touch nothing
        dec_next.op = (32'(cmd.cell_index) < CELLS) ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
      end
      tcw_pkg::ACT_CLEAR: dec_next.op = tcw_pkg::OP_CLEAR;
      default:            dec_next.op = tcw_pkg::OP_NOP;
    endcase
  end

  // Hold the decoded word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      dec_valid <= 1'b1;
    end else if (dec_ready) begin
      dec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      dec <= dec_next;
    end
  end

endmodule

[rtl/core/tcw_fifo.sv]
module tcw_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  tcw_pkg::dec_word_t push_word,
  output logic               pop_valid,
  input  logic               pop,
  output tcw_pkg::dec_word_t pop_word
);

  localparam int PW = $clog2(tcw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

  tcw_pkg::dec_word_t slots [tcw_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = 32'(count) < tcw_pkg::QUEUE_DEPTH;
  assign pop_valid  = count != '0;
  assign pop_word   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == tcw_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == tcw_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

[rtl/core/tcw_back.sv]
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  tcw_pkg::dec_word_t        q_word,
  input  logic [tcw_pkg::ATTR_W-1:0] attr,
  output logic                      res_valid,
  input  logic                      res_ready,
  output tcw_pkg::out_word_t        res
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLUMNS);

  tcw_pkg::back_state_t state;
  tcw_pkg::back_state_t state_next;
  tcw_pkg::dec_word_t   cur;

  // Cursor and screen bookkeeping
  logic [tcw_pkg::COL_W-1:0]  col;
  logic [tcw_pkg::ROW_W-1:0]  row;
  logic [RW-1:0]              top_row;
  logic [ROWS-1:0]            row_valid;
  logic [tcw_pkg::ATTR_W-1:0] row_attr [ROWS];

  // Work registers of the current word
  logic [tcw_pkg::ROW_W-1:0]   work_row;
  logic [tcw_pkg::INDEX_W-1:0] work_rem;
  logic [RW-1:0]               prow;
  logic [ADDR_W-1:0]           base;
  logic [ADDR_W-1:0]           addr;
  logic [CW-1:0]               fill_col;
  logic [tcw_pkg::CELL_W-1:0]  cell_data;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_addr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  logic                       out_free;
  logic                       res_load;
  logic                       next_row_req;
  logic                       fill_last;
  logic [tcw_pkg::ROW_W-1:0]  lrow;
  logic [RW:0]                prow_sum;
  logic [ADDR_W-1:0]          base_calc;
  logic [ADDR_W-1:0]          tcol;

  assign out_free  = !res_valid || res_ready;
  assign fill_last = 32'(fill_col) == COLUMNS - 1;

  // Map logical row onto the circular row order
  assign lrow      = (cur.op == tcw_pkg::OP_READ) ? work_row : row;
  assign prow_sum  = (RW+1)'(top_row) + (RW+1)'(lrow);
  assign base_calc = ADDR_W'(32'(prow) * COLUMNS);
  assign tcol      = (cur.op == tcw_pkg::OP_READ) ? ADDR_W'(work_rem) : ADDR_W'(col);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::BK_IDLE: begin
        if (q_valid) begin
          unique case (q_word.op) inside
            tcw_pkg::OP_PUTC, tcw_pkg::OP_BACKSPACE: state_next = tcw_pkg::BK_PROW;
            tcw_pkg::OP_READ:                        state_next = tcw_pkg::BK_SPLIT;
            default:                                 state_next = tcw_pkg::BK_REPORT;
          endcase
        end
      end
      tcw_pkg::BK_SPLIT: begin
        if (32'(work_rem) < COLUMNS) begin
          state_next = tcw_pkg::BK_PROW;
        end
      end
      tcw_pkg::BK_PROW: state_next = tcw_pkg::BK_ADDR;
      tcw_pkg::BK_ADDR: begin
        if (cur.op == tcw_pkg::OP_READ) begin
          state_next = row_valid[prow] ? tcw_pkg::BK_RDREQ : tcw_pkg::BK_REPORT;
        end else begin
          state_next = row_valid[prow] ? tcw_pkg::BK_WRITE : tcw_pkg::BK_FILL;
        end
      end
      tcw_pkg::BK_FILL: begin
        if (fill_last) begin
          state_next = tcw_pkg::BK_WRITE;
        end
      end
      tcw_pkg::BK_WRITE:  state_next = tcw_pkg::BK_REPORT;
      tcw_pkg::BK_RDREQ:  state_next = tcw_pkg::BK_RDDATA;
      tcw_pkg::BK_RDDATA: state_next = tcw_pkg::BK_REPORT;
      tcw_pkg::BK_REPORT: begin
        if (out_free) begin
          state_next = tcw_pkg::BK_IDLE;
        end
      end
      default: state_next = tcw_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop        = (state == tcw_pkg::BK_IDLE) && q_valid;
    res_load     = (state == tcw_pkg::BK_REPORT) && out_free;
    ram_we       = (state == tcw_pkg::BK_FILL) || (state == tcw_pkg::BK_WRITE);
    ram_addr     = (state == tcw_pkg::BK_FILL) ? base + ADDR_W'(fill_col) : addr;
    if (state == tcw_pkg::BK_FILL) begin
      ram_wdata = {row_attr[prow], tcw_pkg::BLANK_CHAR};
    end else if (cur.op == tcw_pkg::OP_PUTC) begin
      ram_wdata = {attr, cur.char_code};
    end else begin
      ram_wdata = {attr, tcw_pkg::BLANK_CHAR};
    end
    next_row_req = (q_pop && q_word.op == tcw_pkg::OP_NEWLINE) ||
                   (state == tcw_pkg::BK_WRITE && cur.op == tcw_pkg::OP_PUTC &&
                    32'(col) == COLUMNS - 1);
  end

  // Cursor, row order and row status
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::BK_IDLE;
      res_valid <= 1'b0;
      col       <= '0;
      row       <= '0;
      top_row   <= '0;
      row_valid <= '0;
      for (int i = 0; i < ROWS; i++) begin
        row_attr[i] <= tcw_pkg::RESET_ATTR;
      end
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (q_pop && q_word.op == tcw_pkg::OP_BACKSPACE) begin
        // step back, wrapping up a row but never past the corner
        if (col != '0) begin
          col <= col - 1'b1;
        end else if (row != '0) begin
          row <= row - 1'b1;
          col <= tcw_pkg::COL_W'(COLUMNS - 1);
        end
      end
      if (q_pop && q_word.op == tcw_pkg::OP_CLEAR) begin
        // blank every row lazily and home the cursor
        row_valid <= '0;
        for (int i = 0; i < ROWS; i++) begin
          row_attr[i] <= attr;
        end
        col     <= '0;
        row     <= '0;
        top_row <= '0;
      end
      if (state == tcw_pkg::BK_WRITE && cur.op == tcw_pkg::OP_PUTC &&
          32'(col) != COLUMNS - 1) begin
        col <= col + 1'b1;
      end
      if (next_row_req) begin
        col <= '0;
        if (32'(row) == ROWS - 1) begin
          // scroll: the old top row comes back as a blank bottom row
          row_valid[top_row] <= 1'b0;
          row_attr[top_row]  <= attr;
          top_row <= (32'(top_row) == ROWS - 1) ? '0 : top_row + 1'b1;
        end else begin
          row <= row + 1'b1;
        end
      end
      if (state == tcw_pkg::BK_FILL && fill_last) begin
        row_valid[prow] <= 1'b1;
      end
    end
  end

  // Work registers and result
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur       <= q_word;
      work_rem  <= q_word.cell_index;
      work_row  <= '0;
      cell_data <= '0;
    end
    if (state == tcw_pkg::BK_SPLIT && 32'(work_rem) >= COLUMNS) begin
      work_rem <= work_rem - tcw_pkg::INDEX_W'(COLUMNS);
      work_row <= work_row + 1'b1;
    end
    if (state == tcw_pkg::BK_PROW) begin
      prow <= (32'(prow_sum) >= ROWS) ? RW'(32'(prow_sum) - ROWS) : RW'(prow_sum);
    end
    if (state == tcw_pkg::BK_ADDR) begin
      base     <= base_calc;
      addr     <= base_calc + tcol;
      fill_col <= '0;
      if (cur.op == tcw_pkg::OP_READ && !row_valid[prow]) begin
        cell_data <= {row_attr[prow], tcw_pkg::BLANK_CHAR};
      end
    end
    if (state == tcw_pkg::BK_FILL) begin
      fill_col <= fill_col + 1'b1;
    end
    if (state == tcw_pkg::BK_RDDATA) begin
      cell_data <= ram_rdata;
    end
    if (res_load) begin
      res.cursor_index  <= tcw_pkg::INDEX_W'(32'(row) * COLUMNS + 32'(col));
      res.cursor_column <= col;
      res.cursor_row    <= row;
      res.cell_value    <= cell_data;
    end
  end

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

endmodule

[rtl/core/text_console_writer.sv]
// Teletype text console over a ROWS x COLUMNS screen of 16-bit cells
// (attribute high byte, character low byte) held in one single-port RAM.
// Each word on cmd gives exactly one word on res with the cursor after the
// step. Per word, the back-end sequencer with its one RAM port sends
// newline, clear, no-op and out-of-range read straight to the report; put
// character and backspace map the row, form the address and write; a read
// takes whole rows off cell_index, maps the row and reads the RAM, unless
// its row is still blank. Scroll and clear only mark rows as blank, so the
// first write into a blanked row adds a sweep that fills it with blanks.
// Rows are kept in circular order, so no cell ever moves. No clearing pass
// is run after reset; the screen is usable straight away. Words are decoded
// and queued ahead of the sequencer, and the finished result is held in an
// output register, so cmd keeps taking a few words while res is stalled.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  tcw_pkg::in_word_t          cmd,
  output logic                       res_valid,
  input  logic                       res_ready,
  output tcw_pkg::out_word_t         res,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);

  logic [tcw_pkg::ATTR_W-1:0] text_attribute;

  logic               fq_valid;
  logic               fq_ready;
  tcw_pkg::dec_word_t fq_word;
  logic               bq_valid;
  logic               bq_pop;
  tcw_pkg::dec_word_t bq_word;

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tcw_pkg::RESET_ATTR;
    end else if (cfg_we) begin
      text_attribute <= cfg_wdata;
    end
  end

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .dec_valid(fq_valid),
    .dec_ready(fq_ready),
    .dec      (fq_word)
  );

  tcw_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_word (fq_word),
    .pop_valid (bq_valid),
    .pop       (bq_pop),
    .pop_word  (bq_word)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (bq_valid),
    .q_pop    (bq_pop),
    .q_word   (bq_word),
    .attr     (text_attribute),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Reported cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (32'(res.cursor_column) < COLUMNS) && (32'(res.cursor_row) < ROWS))
    else $error("cursor outside the screen");

  // Linear index agrees with row and column
  a_cursor_index: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.cursor_index ==
      tcw_pkg::INDEX_W'(32'(res.cursor_row) * COLUMNS + 32'(res.cursor_column)))
    else $error("cursor index disagrees with row and column");

  // Input stalls only while a decoded word waits for the queue
  a_front_stall: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> fq_valid && !fq_ready)
    else $error("front stalled with nothing held");

endmodule

[tb/text_console_checker.sv]
module text_console_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  logic                       cmd_ready,
  input  tcw_pkg::in_word_t          cmd,
  input  logic                       res_valid,
  input  logic                       res_ready,
  input  tcw_pkg::out_word_t         res,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  // Shadow of the screen, cursor and attribute register
  logic [CELL_W-1:0] screen [CELLS];
  int                col_now;
  int                row_now;
  logic [ATTR_W-1:0] attribute;
  out_word_t         pending_reports [$];
  int                errors;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {attribute, BLANK_CHAR};
  endfunction

  function automatic int cursor_cell();
    int p;
    p = row_now * COLUMNS + col_now;
    return (p < CELLS) ? p : 0;
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
    col_now = 0;
    row_now = 0;
  endfunction

  // Apply one character to the screen, scrolling when the cursor drops off the bottom
  function automatic void put_char(logic [CHAR_W-1:0] c);
    if (c == NEWLINE_CODE) begin
      col_now = 0;
      row_now++;
    end else if (c == BACKSPACE_CODE) begin
      if (col_now != 0) begin
        col_now--;
      end else if (row_now != 0) begin
        row_now--;
        col_now = COLUMNS - 1;
      end
      screen[cursor_cell()] = blank_cell();
    end else begin
      screen[cursor_cell()] = {attribute, c};
      col_now++;
      if (col_now >= COLUMNS) begin
        col_now = 0;
        row_now++;
      end
    end
    if (row_now >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = blank_cell();
      row_now = ROWS - 1;
    end
  endfunction

  // Work out the result word that one command word should produce
  function automatic out_word_t console_step(in_word_t w);
    out_word_t r;
    int        p;
    r = '0;
    case (w.action)
      ACT_PUT: begin
        put_char(w.char_code);
      end
      ACT_READ: begin
        if (w.cell_index < CELLS) r.cell_value = screen[w.cell_index];
      end
      ACT_CLEAR: begin
        blank_screen();
      end
      default: begin
      end
    endcase
    p = row_now * COLUMNS + col_now;
    r.cursor_index  = INDEX_W'(p);
    r.cursor_column = COL_W'(col_now);
    r.cursor_row    = ROW_W'(row_now);
    return r;
  endfunction

  function automatic void check_field(string field_name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (errors < 10)
        $display("%0t: %s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
                 $realtime, field_name, want, want, got, got);
      errors++;
    end
  endfunction

  // Compare returned words against predictions, then record new commands
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      attribute = RESET_ATTR;
      blank_screen();
      pending_reports.delete();
      errors = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (pending_reports.size() == 0) begin
          if (errors < 10)
            $display("%0t: result word with nothing outstanding: 0x%0h", $realtime, res);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("cursor_index", want.cursor_index, res.cursor_index);
          check_field("cursor_column", want.cursor_column, res.cursor_column);
          check_field("cursor_row", want.cursor_row, res.cursor_row);
          check_field("cell_value", want.cell_value, res.cell_value);
        end
      end
      if (cmd_valid && cmd_ready) pending_reports.push_back(console_step(cmd));
      if (cfg_we) attribute = cfg_wdata;
    end
    mismatches <= errors;
    waiting    <= pending_reports.size();
  end

endmodule

[tb/text_console_writer_tb.sv]
module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_AFTER  = 500;
  localparam int HOLD_CYCLES = 500;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cmd_valid = 1'b0;
  in_word_t          cmd       = '0;
  logic              res_ready = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata = '0;
  logic              cmd_ready;
  logic              res_valid;
  out_word_t         res;
  int                mismatches;
  int                waiting;
  int                quiet = 0;
  int                sent  = 0;
  bit                sender_calm = 1'b0;

  always #5 clk = ~clk;

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) uut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  text_console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .waiting   (waiting)
  );

  function automatic in_word_t make_word(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] c,
                                         logic [INDEX_W-1:0] idx);
    in_word_t w;
    w.action     = act;
    w.char_code  = c;
    w.cell_index = idx;
    return w;
  endfunction

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Single random command word, mostly puts and reads with a little noise
  function automatic in_word_t random_word();
    in_word_t w;
    int       r;
    int       k;
    w = make_word(ACT_PUT, CHAR_W'($urandom_range(0, 255)), INDEX_W'($urandom_range(0, 2047)));
    r = $urandom_range(0, 599);
    k = $urandom_range(0, 99);
    if (r < 460) begin
      if (k < 12) w.char_code = NEWLINE_CODE;
      else if (k < 24) w.char_code = BACKSPACE_CODE;
    end else if (r < 580) begin
      w.action = ACT_READ;
      if (k < 80) w.cell_index = INDEX_W'($urandom_range(0, CELLS - 1));
      else if (k < 90) w.cell_index = INDEX_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
      else w.cell_index = INDEX_W'($urandom_range(CELLS, 2047));
    end else if (r < 598) begin
      w.action = ACT_UNUSED;
    end else begin
      w.action = ACT_CLEAR;
    end
    return w;
  endfunction

  // Offer one word, hold it until taken, then maybe idle
  task automatic send_word(input in_word_t w);
    int gap;
    cmd_valid <= 1'b1;
    cmd       <= w;
    do @(posedge clk); while (!cmd_ready);
    sent++;
    if (sent % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A run of printable text, ended by a newline about half the time
  task automatic send_text_line(output int count);
    int len;
    len = $urandom_range(1, 120);
    count = len;
    for (int i = 0; i < len; i++)
      send_word(make_word(ACT_PUT, CHAR_W'($urandom_range(8'h20, 8'h7e)),
                          INDEX_W'($urandom_range(0, 2047))));
    if ($urandom_range(0, 1) == 1) begin
      send_word(make_word(ACT_PUT, NEWLINE_CODE, INDEX_W'($urandom_range(0, 2047))));
      count++;
    end
  endtask

  task automatic random_phase(input int n);
    int count;
    int line_len;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 2) == 0) begin
        send_text_line(line_len);
        count += line_len;
      end else begin
        send_word(random_word());
        count++;
      end
    end
  endtask

  // Drain all outstanding words, let the block settle, then write the attribute
  task automatic set_attribute(input logic [ATTR_W-1:0] a);
    cmd_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (100) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int  taken;
    int  stall;
    int  cycles;
    int  r;
    bit  calm;
    bit  hold_done;
    taken = 0;
    stall = 0;
    cycles = 0;
    calm = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (res_valid && res_ready) taken++;
      if (cycles % 128 == 0) calm = ($urandom_range(0, 3) == 0);
      cycles++;
      if (!hold_done && taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !calm) begin
        r = $urandom_range(0, 99);
        if (r < 15) stall = $urandom_range(1, 3);
        else if (r < 18) stall = $urandom_range(15, 50);
      end
      if (stall > 0) begin
        res_ready <= 1'b0;
        stall--;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset attribute
    send_word(make_word(ACT_READ, 8'h00, 11'd0));
    send_word(make_word(ACT_READ, 8'hff, INDEX_W'(CELLS - 1)));
    send_word(make_word(ACT_READ, 8'h00, INDEX_W'(CELLS)));
    send_word(make_word(ACT_READ, 8'h00, 11'h7ff));
    send_word(make_word(ACT_PUT, BACKSPACE_CODE, 11'd0));
    send_word(make_word(ACT_UNUSED, 8'hff, 11'h7ff));
    send_word(make_word(ACT_PUT, 8'h00, 11'd0));
    send_word(make_word(ACT_PUT, 8'hff, 11'h7ff));
    send_word(make_word(ACT_PUT, 8'h41, 11'd0));
    send_word(make_word(ACT_PUT, BACKSPACE_CODE, 11'd0));
    send_word(make_word(ACT_READ, 8'h00, 11'd2));
    send_word(make_word(ACT_READ, 8'h00, 11'd1));
    send_word(make_word(ACT_PUT, NEWLINE_CODE, 11'd0));
    send_word(make_word(ACT_PUT, BACKSPACE_CODE, 11'd0));
    send_word(make_word(ACT_PUT, 8'h5a, 11'd0));
    send_word(make_word(ACT_READ, 8'h00, INDEX_W'(COLUMNS - 1)));
    send_word(make_word(ACT_PUT, NEWLINE_CODE, 11'd0));
    send_word(make_word(ACT_CLEAR, 8'h00, 11'd0));
    send_word(make_word(ACT_READ, 8'h00, 11'd0));
    send_word(make_word(ACT_READ, 8'h00, INDEX_W'(COLUMNS - 1)));

    // Random phases across several attribute settings, extremes first
    set_attribute(8'h00);
    random_phase(200);
    set_attribute(8'hff);
    random_phase(200);
    set_attribute(RESET_ATTR);
    random_phase(200);
    repeat (5) begin
      set_attribute(ATTR_W'($urandom_range(0, 255)));
      random_phase(200);
    end

    cmd_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
